### src/process_id_allocator_core_defines.svh
// Assertion helpers for the process id allocator.
`ifndef PROCESS_ID_ALLOCATOR_CORE_DEFINES_SVH
`define PROCESS_ID_ALLOCATOR_CORE_DEFINES_SVH

// Checked only while out of reset.
`define PIDA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PIDA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/pida_pkg.sv
package pida_pkg;

  localparam int NUM_IDS  = 64;
  localparam int FIRST_ID = 3;
  localparam int TOTAL    = NUM_IDS - FIRST_ID;  // allocatable ids
  localparam int ID_W     = $clog2(NUM_IDS);
  localparam int CNT_W    = $clog2(TOTAL + 1);
  localparam int REL_W    = 16;
  localparam int GRANT_W  = 6;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef logic [ID_W-1:0] id_t;

  // one write port, one read port of the used map
  typedef struct packed {
    logic we;
    id_t  waddr;
    logic wdata;
    id_t  raddr;
  } map_req_t;

  typedef struct packed {
    logic [GRANT_W-1:0] granted_id;
    logic               ok;
  } res_t;

  // next id in the rotating search, wrapping past the reserved ids
  function automatic id_t advance(input id_t id);
    id_t n;
    if (id == ID_W'(NUM_IDS - 1)) begin
      n = ID_W'(FIRST_ID);
    end else begin
      n = id + ID_W'(1);
    end
    return n;
  endfunction

endpackage

### src/pida_map.sv
module pida_map
  import pida_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  map_req_t req,
  output logic     used
);

  logic               mem_r [NUM_IDS];
  logic [NUM_IDS-1:0] vld_r;
  logic               used_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
  end

  // entry never written reads as free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.we) begin
      vld_r[req.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    used_r <= mem_r[req.raddr] & vld_r[req.raddr];
  end

  assign used = used_r;

endmodule

### src/pida_seq.sv
module pida_seq
  import pida_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             op,
  input  logic [REL_W-1:0] rel_id,
  output logic             idle,
  output logic             res_valid,
  input  logic             res_take,
  output res_t             res,
  output map_req_t         map_req,
  input  logic             map_used
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state_r, state_nxt;
  id_t              ptr_r, ptr_nxt;
  id_t              probe_r, probe_nxt;
  id_t              chk_id_r, chk_id_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic [CNT_W-1:0] issued_r, issued_nxt;
  res_t             res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ptr_r     <= ID_W'(FIRST_ID);
      chk_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ptr_r     <= ptr_nxt;
      chk_vld_r <= chk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    probe_r  <= probe_nxt;
    chk_id_r <= chk_id_nxt;
    issued_r <= issued_nxt;
    res_r    <= res_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    ptr_nxt     = ptr_r;
    probe_nxt   = probe_r;
    chk_id_nxt  = chk_id_r;
    chk_vld_nxt = chk_vld_r;
    issued_nxt  = issued_r;
    res_nxt     = res_r;
    map_req     = '{we: 1'b0, waddr: chk_id_r, wdata: 1'b0, raddr: probe_r};
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (op == OP_ALLOC) begin
            state_nxt   = ST_SCAN;
            probe_nxt   = ptr_r;
            issued_nxt  = '0;
            chk_vld_nxt = 1'b0;
          end else begin
            state_nxt          = ST_DONE;
            res_nxt.granted_id = '0;
            res_nxt.ok         = 1'b0;
            if ({1'b0, rel_id} < (REL_W + 1)'(NUM_IDS)) begin
              map_req.we    = 1'b1;
              map_req.waddr = rel_id[ID_W-1:0];
              map_req.wdata = 1'b0;
              res_nxt.ok    = 1'b1;
            end
          end
        end
      end
      ST_SCAN: begin
        // issue one probe per cycle, check the one read last cycle
        chk_vld_nxt = 1'b0;
        if (issued_r != CNT_W'(TOTAL)) begin
          chk_id_nxt  = probe_r;
          chk_vld_nxt = 1'b1;
          probe_nxt   = advance(probe_r);
          issued_nxt  = issued_r + CNT_W'(1);
        end
        if (chk_vld_r && !map_used) begin
          map_req.we         = 1'b1;
          map_req.waddr      = chk_id_r;
          map_req.wdata      = 1'b1;
          res_nxt.granted_id = GRANT_W'(chk_id_r);
          res_nxt.ok         = 1'b1;
          ptr_nxt            = advance(chk_id_r);
          chk_vld_nxt        = 1'b0;
          state_nxt          = ST_DONE;
        end else if (chk_vld_r && issued_r == CNT_W'(TOTAL)) begin
          // full sweep, nothing free
          res_nxt.granted_id = '0;
          res_nxt.ok         = 1'b0;
          chk_vld_nxt        = 1'b0;
          state_nxt          = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt   = ST_IDLE;
        chk_vld_nxt = 1'b0;
      end
    endcase
  end

  assign idle      = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res       = res_r;

endmodule

### src/process_id_allocator_core.sv
// Channel | Ports                          | Payload
// in      | in_tvalid/in_tready            | tuser: op; tdata: release_id
// out     | out_tvalid/out_tready          | tdata: granted_id (+2 zero bits); tuser: ok
//
// Release: the result register loads straight from the request. Allocate: one map
// probe per cycle through the single read port of the used map; the first free id
// from the search pointer is granted, and a full map ends the sweep with ok low.
// One request is in work at a time; in_tready is high only while idle.
// Synchronous active-low reset; the used map reads as all free right after it.
// A held output does not block the next request until its result is ready.
module process_id_allocator_core
  import pida_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [REL_W-1:0] in_tdata,   // [15:0] release_id
  input  logic             in_tuser,   // [0] op
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,  // [5:0] granted_id, [7:6] zero
  output logic             out_tuser   // [0] ok
);

  logic     seq_idle;
  logic     res_valid;
  logic     res_take;
  res_t     res;
  map_req_t map_req;
  logic     map_used;

  logic       out_vld_r;
  logic [7:0] out_data_r;
  logic       out_user_r;

  // sequencer: pointer, probe counter, result pending
  pida_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_tvalid & seq_idle),
    .op        (in_tuser),
    .rel_id    (in_tdata),
    .idle      (seq_idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .map_req   (map_req),
    .map_used  (map_used)
  );

  // used-bit map, registered read
  pida_map u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (map_req),
    .used  (map_used)
  );

  assign in_tready = seq_idle;

  // output register: load when empty or being drained
  assign res_take = res_valid & (~out_vld_r | out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_take) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= 8'(res.granted_id);
      out_user_r <= res.ok;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

### src/pida_chk.sv
`include "process_id_allocator_core_defines.svh"

module pida_chk
  import pida_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [REL_W-1:0] in_tdata,
  input logic             in_tuser,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [7:0]       out_tdata,
  input logic             out_tuser
);

  // nothing left valid after reset
  `PIDA_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_tvalid, "out_tvalid set after reset")

  // one request in work at a time
  `PIDA_ASSERT(a_one_req, (in_tvalid && in_tready) |=> !in_tready, "request taken while busy")

  // waiting request holds
  `PIDA_ASSERT(a_in_hold, (in_tvalid && !in_tready) |=>
    (in_tvalid && $stable(in_tdata) && $stable(in_tuser)), "request changed while waiting")

  // failed request never carries an id
  `PIDA_ASSERT(a_fail_zero, (out_tvalid && !out_tuser) |-> (out_tdata == 8'd0), "id on failure")

  // stalled result holds
  `PIDA_ASSERT(a_hold, (out_tvalid && !out_tready) |=>
    (out_tvalid && $stable(out_tdata) && $stable(out_tuser)), "result changed under stall")

endmodule

bind process_id_allocator_core pida_chk u_pida_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
